// ===== rtl/bst_pkg.sv =====
// Shared types, constants and byte classification for the byte stream tokenizer.
// No dependencies; every other file of the block imports this package.
package bst_pkg;

  // Default counter width and fixed field widths of the result channel
  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned OFS_W          = 24;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned BYTE_W         = 8;

  // Result queue depth (power of two)
  localparam int unsigned TOKQ_DEPTH = 4;

  // Separator, line break and digit codes
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // Token kinds
  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_PUNCT = 1'b1;

  typedef enum logic [1:0] {
    CLS_WORD,
    CLS_SEP,
    CLS_BRK,
    CLS_PUNCT
  } byte_cls_e;

  // One result item
  typedef struct packed {
    logic              token_kind;
    logic [BYTE_W-1:0] token_char;
    logic [OFS_W-1:0]  start_offset;
    logic [OFS_W-1:0]  token_length;
    logic [OFS_W-1:0]  line_number;
    logic [OFS_W-1:0]  column_number;
    logic              all_digits;
    logic [VAL_W-1:0]  number_value;
    logic              number_saturated;
    logic              last_of_item;
  } token_t;

  // Tokens produced by one input item, first in order at tok0
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  // Sort a text byte into word, separator, line break or punctuation
  function automatic byte_cls_e classify(input logic [BYTE_W-1:0] b);
    byte_cls_e cls;
    case (b) inside
      CH_SPACE, CH_TAB: cls = CLS_SEP;
      CH_LF, CH_CR:     cls = CLS_BRK;
      8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26,
      8'h2A, 8'h28, 8'h29, 8'h2B, 8'h60, 8'h2D, 8'h3D, 8'h7B,
      8'h7D, 8'h7C, 8'h3A, 8'h22, 8'h5B, 8'h5D, 8'h5C, 8'h3B,
      8'h27, 8'h3C, 8'h3E, 8'h3F, 8'h2C, 8'h2E, 8'h2F: cls = CLS_PUNCT;
      default:          cls = CLS_WORD;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/bst_in_if.sv =====
// Input channel of the tokenizer: one text byte or an end-of-text marker per transfer.
// Depends on bst_pkg for field widths.
interface bst_in_if;
  import bst_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/bst_tok_if.sv =====
// Result channel of the tokenizer: one token per transfer.
// Depends on bst_pkg for field widths.
interface bst_tok_if;
  import bst_pkg::*;

  logic              valid;
  logic              ready;
  logic              token_kind;
  logic [BYTE_W-1:0] token_char;
  logic [OFS_W-1:0]  start_offset;
  logic [OFS_W-1:0]  token_length;
  logic [OFS_W-1:0]  line_number;
  logic [OFS_W-1:0]  column_number;
  logic              all_digits;
  logic [VAL_W-1:0]  number_value;
  logic              number_saturated;
  logic              last_of_item;

  modport source (
    output valid, input ready,
    output token_kind, output token_char, output start_offset, output token_length,
    output line_number, output column_number, output all_digits, output number_value,
    output number_saturated, output last_of_item
  );
  modport sink (
    input valid, output ready,
    input token_kind, input token_char, input start_offset, input token_length,
    input line_number, input column_number, input all_digits, input number_value,
    input number_saturated, input last_of_item
  );
  modport monitor (
    input valid, input ready,
    input token_kind, input token_char, input start_offset, input token_length,
    input line_number, input column_number, input all_digits, input number_value,
    input number_saturated, input last_of_item
  );
endinterface

// ===== rtl/bst_scan.sv =====
// Input register, tokenizer state and token build for one byte per cycle while the queue has room.
// Depends on bst_pkg and bst_in_if.
module bst_scan #(
  parameter int unsigned COUNT_BITS = bst_pkg::COUNT_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bst_in_if.sink         in_i,
  input  logic           room2_i,
  output bst_pkg::push_t push_o
);
  import bst_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam int unsigned           NV_W     = VAL_W + 4;

  // Input register
  logic              vld_q;
  logic [BYTE_W-1:0] byte_q;
  logic              eot_q;
  logic              fire;

  // Tokenizer state
  logic                  in_word_q,     in_word_d;
  logic [COUNT_BITS-1:0] position_q,    position_d;
  logic [COUNT_BITS-1:0] line_q,        line_d;
  logic [COUNT_BITS-1:0] column_q,      column_d;
  logic [COUNT_BITS-1:0] word_start_q,  word_start_d;
  logic [COUNT_BITS-1:0] word_line_q,   word_line_d;
  logic [COUNT_BITS-1:0] word_column_q, word_column_d;
  logic [COUNT_BITS-1:0] word_length_q, word_length_d;
  logic                  digits_only_q, digits_only_d;
  logic [VAL_W-1:0]      value_acc_q,   value_acc_d;
  logic                  value_over_q,  value_over_d;

  byte_cls_e             cls;
  logic                  is_dig;
  logic [3:0]            digit;
  logic [NV_W-1:0]       val_ext;
  logic [NV_W-1:0]       nv;
  logic [COUNT_BITS-1:0] pos_inc, col_inc, line_inc, len_inc;
  logic                  flush, punct;
  token_t                word_tok, punct_tok;

  assign fire       = vld_q && room2_i;
  assign in_i.ready = !vld_q || room2_i;

  // Hold the accepted item until the queue has room for its tokens
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.text_byte;
      eot_q  <= in_i.end_of_text;
    end
  end

  // Classify the byte and prepare the saturating increments
  assign cls      = classify(byte_q);
  assign is_dig   = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign digit    = is_dig ? byte_q[3:0] : 4'd0;
  assign val_ext  = NV_W'(value_acc_q);
  assign nv       = (val_ext << 3) + (val_ext << 1) + NV_W'(digit);
  assign pos_inc  = (position_q == CNT_MAX) ? position_q : position_q + CNT_ONE;
  assign col_inc  = (column_q == CNT_MAX) ? column_q : column_q + CNT_ONE;
  assign line_inc = (line_q == CNT_MAX) ? line_q : line_q + CNT_ONE;
  assign len_inc  = (word_length_q == CNT_MAX) ? word_length_q : word_length_q + CNT_ONE;

  assign flush = in_word_q && (eot_q || (cls != CLS_WORD));
  assign punct = !eot_q && (cls == CLS_PUNCT);

  // Build the pending word token and the punctuation token
  always_comb begin
    word_tok                  = '0;
    word_tok.token_kind       = KIND_WORD;
    word_tok.start_offset     = OFS_W'(word_start_q);
    word_tok.token_length     = OFS_W'(word_length_q);
    word_tok.line_number      = OFS_W'(word_line_q);
    word_tok.column_number    = OFS_W'(word_column_q);
    word_tok.all_digits       = digits_only_q;
    word_tok.number_value     = digits_only_q ? value_acc_q : '0;
    word_tok.number_saturated = digits_only_q && value_over_q;
    word_tok.last_of_item     = !punct;

    punct_tok               = '0;
    punct_tok.token_kind    = KIND_PUNCT;
    punct_tok.token_char    = byte_q;
    punct_tok.start_offset  = OFS_W'(position_q);
    punct_tok.token_length  = OFS_W'(CNT_ONE);
    punct_tok.line_number   = OFS_W'(line_q);
    punct_tok.column_number = OFS_W'(column_q);
    punct_tok.last_of_item  = 1'b1;
  end

  // Order the tokens: a flushed word always comes first
  always_comb begin
    push_o.cnt  = 2'd0;
    push_o.tok0 = flush ? word_tok : punct_tok;
    push_o.tok1 = punct_tok;
    if (fire) begin
      push_o.cnt = {1'b0, flush} + {1'b0, punct};
    end
  end

  // Next state
  always_comb begin
    in_word_d     = in_word_q;
    position_d    = position_q;
    line_d        = line_q;
    column_d      = column_q;
    word_start_d  = word_start_q;
    word_line_d   = word_line_q;
    word_column_d = word_column_q;
    word_length_d = word_length_q;
    digits_only_d = digits_only_q;
    value_acc_d   = value_acc_q;
    value_over_d  = value_over_q;
    if (eot_q) begin
      in_word_d  = 1'b0;
      position_d = CNT_ZERO;
      line_d     = CNT_ONE;
      column_d   = CNT_ONE;
    end else begin
      position_d = pos_inc;
      case (cls)
        CLS_SEP, CLS_PUNCT: begin
          in_word_d = 1'b0;
          column_d  = col_inc;
        end
        CLS_BRK: begin
          in_word_d = 1'b0;
          line_d    = line_inc;
          column_d  = CNT_ONE;
        end
        default: begin
          column_d = col_inc;
          if (!in_word_q) begin
            // open a new word at this byte
            in_word_d     = 1'b1;
            word_start_d  = position_q;
            word_line_d   = line_q;
            word_column_d = column_q;
            word_length_d = CNT_ONE;
            digits_only_d = is_dig;
            value_acc_d   = VAL_W'(digit);
            value_over_d  = 1'b0;
          end else begin
            word_length_d = len_inc;
            if (!is_dig) begin
              digits_only_d = 1'b0;
            end else if (digits_only_q && !value_over_q) begin
              // accumulate, clamping once the value leaves 32 bits
              if (|nv[NV_W-1:VAL_W]) begin
                value_acc_d  = '1;
                value_over_d = 1'b1;
              end else begin
                value_acc_d = nv[VAL_W-1:0];
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q     <= 1'b0;
      position_q    <= CNT_ZERO;
      line_q        <= CNT_ONE;
      column_q      <= CNT_ONE;
      word_start_q  <= CNT_ZERO;
      word_line_q   <= CNT_ONE;
      word_column_q <= CNT_ONE;
      word_length_q <= CNT_ZERO;
      digits_only_q <= 1'b1;
      value_acc_q   <= '0;
      value_over_q  <= 1'b0;
    end else if (fire) begin
      in_word_q     <= in_word_d;
      position_q    <= position_d;
      line_q        <= line_d;
      column_q      <= column_d;
      word_start_q  <= word_start_d;
      word_line_q   <= word_line_d;
      word_column_q <= word_column_d;
      word_length_q <= word_length_d;
      digits_only_q <= digits_only_d;
      value_acc_q   <= value_acc_d;
      value_over_q  <= value_over_d;
    end
  end

endmodule

// ===== rtl/bst_tok_fifo.sv =====
// Result queue: takes up to two tokens a cycle, hands out one per transfer.
// Depends on bst_pkg and bst_tok_if.
module bst_tok_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bst_pkg::push_t push_i,
  output logic           room2_o,
  bst_tok_if.source      tok_o
);
  import bst_pkg::*;

  localparam int unsigned PTR_W = $clog2(TOKQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(TOKQ_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(TOKQ_DEPTH - 2);

  token_t             mem_q [TOKQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q,    cnt_d;
  logic               pop;
  token_t             head;

  assign pop     = tok_o.valid && tok_o.ready;
  assign room2_o = (cnt_q <= ROOM_LIMIT);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + CNT_W'(push_i.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the tokens of one item in consecutive slots
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.tok1;
    end
  end

  // Present the head token
  assign head                   = mem_q[rd_ptr_q];
  assign tok_o.valid            = (cnt_q != '0);
  assign tok_o.token_kind       = head.token_kind;
  assign tok_o.token_char       = head.token_char;
  assign tok_o.start_offset     = head.start_offset;
  assign tok_o.token_length     = head.token_length;
  assign tok_o.line_number      = head.line_number;
  assign tok_o.column_number    = head.column_number;
  assign tok_o.all_digits       = head.all_digits;
  assign tok_o.number_value     = head.number_value;
  assign tok_o.number_saturated = head.number_saturated;
  assign tok_o.last_of_item     = head.last_of_item;

endmodule

// ===== rtl/byte_stream_tokenizer_core.sv =====
// Top level of the byte stream tokenizer: scanner stage and result queue.
// Depends on bst_pkg, bst_in_if, bst_tok_if, bst_scan and bst_tok_fifo.
//
// The block takes one text byte per cycle while the queue has room and splits
// the stream into word and punctuation tokens. A byte is registered on
// transfer and scanned from that register once the queue has room for its
// tokens, which then enter a four-entry result queue whose head is offered on
// the result port. An item yields zero, one or two tokens (a word closed by a
// punctuation byte gives the word, then the punctuation); the result port hands
// out one token per cycle while the sink is ready, so the sustained rate is one
// byte per cycle as long as items average no more than one token. The input
// stalls while a byte waits in its register and the queue has fewer than two
// free entries. Counters are COUNT_BITS wide and saturate; end_of_text flushes
// any open word and restarts offset, line and column for the next buffer.
module byte_stream_tokenizer_core #(
  parameter int unsigned COUNT_BITS = bst_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bst_in_if.sink    in_i,
  bst_tok_if.source tok_o
);
  import bst_pkg::*;

  push_t push;
  logic  room2;

  // Scan each byte against the tokenizer state
  bst_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .room2_i (room2),
    .push_o  (push)
  );

  // Queue tokens towards the result port
  bst_tok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .tok_o   (tok_o)
  );

endmodule

// ===== rtl/bst_checker.sv =====
// Port-level checks on the tokenizer result channel, bound to the top level.
// Depends on bst_pkg and byte_stream_tokenizer_core.
module bst_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tok_valid_i,
  input  logic                      tok_ready_i,
  input  logic                      tok_kind_i,
  input  logic [bst_pkg::OFS_W-1:0] tok_start_i,
  input  logic [bst_pkg::OFS_W-1:0] tok_length_i,
  input  logic                      tok_digits_i,
  input  logic [bst_pkg::VAL_W-1:0] tok_value_i,
  input  logic                      tok_sat_i,
  input  logic                      tok_last_i
);
  import bst_pkg::*;

  // Hold a stalled token unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_ready_i |=> tok_valid_i && $stable(tok_start_i)
      && $stable(tok_kind_i) && $stable(tok_last_i))
    else $error("stalled token changed");

  // Only a flushed word may precede another token of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_last_i |-> tok_kind_i == KIND_WORD)
    else $error("punctuation token not last of its item");

  // Punctuation is one byte with no numeric content
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_kind_i == KIND_PUNCT |->
      tok_length_i == OFS_W'(1) && !tok_digits_i
      && tok_value_i == '0 && !tok_sat_i)
    else $error("malformed punctuation token");

  // A saturated value is a clamped digit word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_sat_i |->
      tok_digits_i && tok_value_i == '1)
    else $error("saturation flag without clamped digit word");

  // Drop the value of words that are not all digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_digits_i |-> tok_value_i == '0)
    else $error("value reported for non-digit token");

endmodule

bind byte_stream_tokenizer_core bst_checker u_bst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tok_valid_i  (tok_o.valid),
  .tok_ready_i  (tok_o.ready),
  .tok_kind_i   (tok_o.token_kind),
  .tok_start_i  (tok_o.start_offset),
  .tok_length_i (tok_o.token_length),
  .tok_digits_i (tok_o.all_digits),
  .tok_value_i  (tok_o.number_value),
  .tok_sat_i    (tok_o.number_saturated),
  .tok_last_i   (tok_o.last_of_item)
);
